@@ hdl/tad_pkg.sv @@
package tad_pkg;

    localparam int ZOOM_W   = 5;
    localparam int TILE_W   = 22;
    localparam int LEVEL_W  = 5;
    localparam int COORD_W  = 25;
    localparam int KEY_W    = 56;
    localparam int ENTRY_W  = KEY_W + 1;
    localparam int HASH_W   = 64;
    localparam int HALF_W   = 32;
    localparam int MIX_SHIFT = 33;
    localparam int QDEPTH   = 4;

    localparam logic [ZOOM_W-1:0]  MAX_ZOOM    = 5'd22;
    localparam logic [LEVEL_W-1:0] ZOOM_OFFSET = 5'd3;

    localparam logic [HASH_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [HASH_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

    typedef logic [1:0] status_t;
    localparam status_t ST_NEW     = 2'd0;
    localparam status_t ST_PRESENT = 2'd1;
    localparam status_t ST_FULL    = 2'd2;

    // One key of a walk, as passed from the front to the back.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
        logic               none;
    } walk_item_t;

endpackage

@@ hdl/tad_ram.sv @@
module tad_ram #(
    parameter int WIDTH = 57,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/tad_queue.sv @@
module tad_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tad_pkg::walk_item_t wr_item,
    output logic                full,
    input  logic                pop,
    output tad_pkg::walk_item_t rd_item,
    output logic                empty
);
    import tad_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);

    walk_item_t       slots_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == (PTR_W+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hdl/tad_front.sv @@
module tad_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [4:0]          tile_zoom,
    input  logic [21:0]         tile_x,
    input  logic [21:0]         tile_y,
    input  logic [4:0]          min_zoom,
    output tad_pkg::walk_item_t item,
    output logic                item_push,
    input  logic                item_full
);
    import tad_pkg::*;

    typedef enum logic {F_IDLE, F_WALK} fstate_t;

    fstate_t             state_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [COORD_W-1:0]  x_reg, y_reg;
    logic                none_reg;
    logic [ZOOM_W-1:0]   zoom_clamped;
    logic [LEVEL_W-1:0]  start_level;

    always_comb
    begin
        zoom_clamped = (tile_zoom > MAX_ZOOM) ? MAX_ZOOM : tile_zoom;
        start_level  = zoom_clamped + ZOOM_OFFSET;
        full         = (state_reg == F_WALK);
        item_push    = (state_reg == F_WALK) && !item_full;
        item.level   = none_reg ? '0 : level_reg;
        item.x       = none_reg ? '0 : x_reg;
        item.y       = none_reg ? '0 : y_reg;
        item.none    = none_reg;
        item.last    = none_reg || (level_reg == min_zoom);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            level_reg <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            none_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (push)
                    begin
                        level_reg <= start_level;
                        x_reg     <= {tile_x, 3'b000};
                        y_reg     <= {tile_y, 3'b000};
                        none_reg  <= (start_level < min_zoom);
                        state_reg <= F_WALK;
                    end
                end
                F_WALK:
                begin
                    if (!item_full)
                    begin
                        if (item.last)
                        begin
                            state_reg <= F_IDLE;
                        end
                        else
                        begin
                            // Parent metatile: drop one level, coordinate (c >> 4) << 3.
                            level_reg <= level_reg - 1'b1;
                            x_reg     <= {1'b0, x_reg[COORD_W-1:4], 3'b000};
                            y_reg     <= {1'b0, y_reg[COORD_W-1:4], 3'b000};
                        end
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/tad_back.sv @@
module tad_back #(
    parameter int TABLE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tad_pkg::walk_item_t item,
    input  logic                item_empty,
    output logic                item_pop,
    output logic                clearing,
    output logic                empty,
    input  logic                pop,
    output logic [4:0]          meta_level,
    output logic [24:0]         meta_x,
    output logic [24:0]         meta_y,
    output logic [1:0]          insert_status,
    output logic                last_of_run,
    output logic                none_tried
);
    import tad_pkg::*;

    localparam int DEPTH   = 1 << TABLE_BITS;
    localparam int CNT_W   = TABLE_BITS + 1;
    localparam int PROD_W  = CNT_W + 4;
    localparam logic [PROD_W-1:0] LOAD_LIMIT = PROD_W'(DEPTH) * PROD_W'(7);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_MIX, S_PROBE, S_CHECK, S_EMIT} bstate_t;

    bstate_t               state_reg;
    walk_item_t            cur_reg;
    logic [HASH_W-1:0]     mul_a_reg, acc_reg;
    logic [1:0]            step_reg;
    logic                  pass_reg;
    logic [TABLE_BITS-1:0] slot_reg;
    logic [CNT_W-1:0]      count_reg;
    status_t               st_reg;
    logic                  discard_reg;
    logic                  clr_busy_reg;
    logic [TABLE_BITS-1:0] clr_addr_reg;
    logic                  out_valid_reg;
    walk_item_t            out_item_reg;
    status_t               out_st_reg;
    logic                  out_last_reg;

    logic [HASH_W-1:0]  key64, key_mixed, acc_mixed, mul_c;
    logic [HALF_W-1:0]  mul_x, mul_y;
    logic [2*HALF_W-1:0] prod;
    logic [PROD_W-1:0]  count_x10;
    logic [ENTRY_W-1:0] entry_key, rdata;
    logic               ram_we, ram_re, ins_we, out_free, emit;
    logic [TABLE_BITS-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;

    always_comb
    begin
        key64     = {9'b0, cur_reg.level, cur_reg.x, cur_reg.y};
        key_mixed = {9'b0, item.level, item.x, item.y};
        key_mixed = key_mixed ^ (key_mixed >> MIX_SHIFT);
        acc_mixed = acc_reg ^ (acc_reg >> MIX_SHIFT);
        entry_key = {1'b1, key64[KEY_W-1:0]};
        mul_c     = pass_reg ? MIX_C2 : MIX_C1;
        // Low 64 bits of a 64x64 product, one 32x32 partial product per step.
        case (step_reg)
            2'd0:    begin mul_x = mul_a_reg[31:0];  mul_y = mul_c[31:0];  end
            2'd1:    begin mul_x = mul_a_reg[31:0];  mul_y = mul_c[63:32]; end
            default: begin mul_x = mul_a_reg[63:32]; mul_y = mul_c[31:0];  end
        endcase
        prod      = mul_x * mul_y;
        count_x10 = (PROD_W'(count_reg) << 3) + (PROD_W'(count_reg) << 1);
        out_free  = !out_valid_reg || pop;
        emit      = (state_reg == S_EMIT) && out_free;
        item_pop  = (state_reg == S_IDLE) && !clr_busy_reg && !item_empty;
        ins_we    = (state_reg == S_CHECK) && !rdata[KEY_W] && !(count_x10 > LOAD_LIMIT);
        ram_we    = clr_busy_reg || ins_we;
        ram_waddr = clr_busy_reg ? clr_addr_reg : slot_reg;
        ram_wdata = clr_busy_reg ? '0 : entry_key;
        ram_re    = (state_reg == S_PROBE);
        clearing  = clr_busy_reg;
        empty         = !out_valid_reg;
        meta_level    = out_item_reg.level;
        meta_x        = out_item_reg.x;
        meta_y        = out_item_reg.y;
        insert_status = out_st_reg;
        last_of_run   = out_last_reg;
        none_tried    = out_item_reg.none;
    end

    tad_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_item_reg <= cur_reg;
            out_st_reg   <= st_reg;
            out_last_reg <= cur_reg.last || (st_reg == ST_PRESENT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            mul_a_reg     <= '0;
            acc_reg       <= '0;
            step_reg      <= '0;
            pass_reg      <= 1'b0;
            slot_reg      <= '0;
            count_reg     <= '0;
            st_reg        <= ST_NEW;
            discard_reg   <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (item_pop)
                    begin
                        if (discard_reg)
                        begin
                            if (item.last)
                            begin
                                discard_reg <= 1'b0;
                            end
                        end
                        else
                        begin
                            cur_reg   <= item;
                            st_reg    <= ST_NEW;
                            mul_a_reg <= key_mixed;
                            step_reg  <= '0;
                            pass_reg  <= 1'b0;
                            state_reg <= item.none ? S_EMIT : S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    case (step_reg)
                        2'd0:    acc_reg <= prod;
                        default: acc_reg <= acc_reg + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
                    endcase
                    if (step_reg == 2'd2)
                    begin
                        state_reg <= S_MIX;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_MIX:
                begin
                    if (!pass_reg)
                    begin
                        mul_a_reg <= acc_mixed;
                        pass_reg  <= 1'b1;
                        step_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        slot_reg  <= acc_mixed[TABLE_BITS-1:0];
                        state_reg <= S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (!rdata[KEY_W])
                    begin
                        if (ins_we)
                        begin
                            count_reg <= count_reg + 1'b1;
                            st_reg    <= ST_NEW;
                        end
                        else
                        begin
                            st_reg <= ST_FULL;
                        end
                        state_reg <= S_EMIT;
                    end
                    else if (rdata == entry_key)
                    begin
                        st_reg    <= ST_PRESENT;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= S_PROBE;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        // A hit ends the walk: drop the rest of this run's keys.
                        if ((st_reg == ST_PRESENT) && !cur_reg.last)
                        begin
                            discard_reg <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> (state_reg == S_IDLE))
        else $error("store clearing overlapped a lookup");

    a_check_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK) |-> ($past(state_reg) == S_PROBE))
        else $error("slot compared without a read");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_x10 <= LOAD_LIMIT + PROD_W'(10))
        else $error("entry count passed the load limit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> $stable(out_st_reg))
        else $error("waiting result overwritten");

endmodule

@@ hdl/tile_ancestor_dedup_hash_set.sv @@
// Tile ancestor deduplication set.
// Input channel: drive tile_zoom, tile_x and tile_y with push high; the beat is
// taken at a clock edge where full is low. Each tile becomes a walk of metatile
// keys from level zoom+3, zoom clamped to 22, up to min_zoom; every key is hashed
// and inserted into a linear-probing store of 2^TABLE_BITS slots while under its
// load limit, and the walk stops at the first key already present.
// Result channel: one beat per level tried, oldest first, shown while empty is
// low and taken with pop. last_of_run marks the final beat of a tile.
// Flow: the front walker issues one key a cycle into a four-entry queue while
// the queue has room; the back unit finishes one key before it takes the next,
// hashing it with two 64-bit multiplies done as three 32x32 partial products
// each, then a read and a compare per probed slot.
// Reset clears the walk, the entry count and the queues and loads min_zoom with
// 13; then the key store's 2^TABLE_BITS slots are cleared one slot a cycle,
// during which full stays high. min_zoom is written with cfg_we and cfg_wdata.
// If the receiver stalls, the waiting result holds, the back unit stops at its
// next result, the queue fills and full rises; nothing is lost.
module tile_ancestor_dedup_hash_set #(
    parameter int TABLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [4:0]  tile_zoom,
    input  logic [21:0] tile_x,
    input  logic [21:0] tile_y,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  meta_level,
    output logic [24:0] meta_x,
    output logic [24:0] meta_y,
    output logic [1:0]  insert_status,
    output logic        last_of_run,
    output logic        none_tried,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);
    import tad_pkg::*;

    localparam logic [4:0] MIN_ZOOM_RESET = 5'd13;

    logic [4:0] min_zoom_reg;
    logic       front_full, clearing;
    walk_item_t front_item, queue_item;
    logic       front_push, queue_full, queue_pop, queue_empty;

    // Inputs are held off while the store is being cleared.
    assign full = front_full || clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_zoom_reg <= MIN_ZOOM_RESET;
        end
        else if (cfg_we)
        begin
            min_zoom_reg <= cfg_wdata;
        end
    end

    tad_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push && !clearing),
        .full      (front_full),
        .tile_zoom (tile_zoom),
        .tile_x    (tile_x),
        .tile_y    (tile_y),
        .min_zoom  (min_zoom_reg),
        .item      (front_item),
        .item_push (front_push),
        .item_full (queue_full)
    );

    tad_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .wr_item (front_item),
        .full    (queue_full),
        .pop     (queue_pop),
        .rd_item (queue_item),
        .empty   (queue_empty)
    );

    tad_back #(
        .TABLE_BITS (TABLE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (queue_item),
        .item_empty    (queue_empty),
        .item_pop      (queue_pop),
        .clearing      (clearing),
        .empty         (empty),
        .pop           (pop),
        .meta_level    (meta_level),
        .meta_x        (meta_x),
        .meta_y        (meta_y),
        .insert_status (insert_status),
        .last_of_run   (last_of_run),
        .none_tried    (none_tried)
    );

endmodule

@@ test/tb_tile_ancestor_dedup_hash_set.sv @@
`timescale 1ns / 1ps

typedef struct {
    logic [4:0]  level;
    logic [24:0] mx;
    logic [24:0] my;
    logic [1:0]  status;
    logic        last;
    logic        none;
} meta_beat_t;

// Ancestor-walk predictor with its own copy of the hash set, and the queue of
// metatile results that it expects the block to return, oldest first.
class metatile_board;
    localparam int SLOTS = 1 << 16;

    logic [56:0] slot_key [SLOTS];
    int unsigned used_slots;
    logic [4:0]  lowest_level;
    meta_beat_t  pending [$];
    int          errors;

    function new();
        foreach (slot_key[i]) slot_key[i] = '0;
        used_slots = 0;
        lowest_level = 5'd13;
        errors = 0;
    endfunction

    function logic [63:0] fmix(logic [63:0] v);
        v = v ^ (v >> 33);
        v = v * 64'hff51afd7ed558ccd;
        v = v ^ (v >> 33);
        v = v * 64'hc4ceb9fe1a85ec53;
        v = v ^ (v >> 33);
        return v;
    endfunction

    function logic [1:0] add_key(logic [55:0] k);
        logic [63:0] h;
        logic [15:0] s;
        logic [56:0] marked;
        int n;
        h = fmix({8'd0, k});
        s = h[15:0];
        marked = {1'b1, k};
        for (n = 0; n < SLOTS; n++)
        begin
            if (!slot_key[s][56])
                break;
            if (slot_key[s] == marked)
                return tad_pkg::ST_PRESENT;
            s = s + 16'd1;
        end
        if (n == SLOTS || longint'(used_slots) * 10 > longint'(SLOTS) * 7)
            return tad_pkg::ST_FULL;
        slot_key[s] = marked;
        used_slots++;
        return tad_pkg::ST_NEW;
    endfunction

    function void note_tile(logic [4:0] z, logic [21:0] x, logic [21:0] y);
        int lvl;
        logic [24:0] cx, cy;
        meta_beat_t b;
        if (z > 5'd22)
            z = 5'd22;
        lvl = int'(z) + 3;
        cx = {x, 3'b000};
        cy = {y, 3'b000};
        if (lvl < int'(lowest_level))
        begin
            b = '{5'd0, 25'd0, 25'd0, tad_pkg::ST_NEW, 1'b1, 1'b1};
            pending.push_back(b);
            return;
        end
        while (lvl >= int'(lowest_level))
        begin
            b.level = lvl[4:0];
            b.mx = cx;
            b.my = cy;
            b.status = add_key({lvl[5:0], cx, cy});
            b.last = 1'b0;
            b.none = 1'b0;
            pending.push_back(b);
            if (b.status == tad_pkg::ST_PRESENT)
                break;
            lvl--;
            cx = (cx >> 4) << 3;
            cy = (cy >> 4) << 3;
        end
        pending[$].last = 1'b1;
    endfunction

    function void check_beat(meta_beat_t got);
        meta_beat_t w;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result beat level=%0d x=%0d y=%0d", $time,
                     got.level, got.mx, got.my);
            errors++;
            return;
        end
        w = pending.pop_front();
        if (got.level !== w.level)
        begin
            $display("%0t: meta_level expected %0d actual %0d", $time, w.level, got.level);
            errors++;
        end
        if (got.mx !== w.mx)
        begin
            $display("%0t: meta_x expected %0d actual %0d", $time, w.mx, got.mx);
            errors++;
        end
        if (got.my !== w.my)
        begin
            $display("%0t: meta_y expected %0d actual %0d", $time, w.my, got.my);
            errors++;
        end
        if (got.status !== w.status)
        begin
            $display("%0t: insert_status expected %0d actual %0d", $time, w.status,
                     got.status);
            errors++;
        end
        if (got.last !== w.last)
        begin
            $display("%0t: last_of_run expected %0b actual %0b", $time, w.last, got.last);
            errors++;
        end
        if (got.none !== w.none)
        begin
            $display("%0t: none_tried expected %0b actual %0b", $time, w.none, got.none);
            errors++;
        end
    endfunction
endclass

module tb_tile_ancestor_dedup_hash_set;
    import tad_pkg::*;

    // The block clears its store slot by slot after reset, and a tile of many
    // levels with long probe chains adds more time on top. The limit below covers
    // all of that many times over.
    localparam int CYCLE_LIMIT = 1500000;
    localparam int RANDOM_TILES = 225;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [4:0]  tile_zoom = '0;
    logic [21:0] tile_x = '0;
    logic [21:0] tile_y = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [4:0]  meta_level;
    logic [24:0] meta_x;
    logic [24:0] meta_y;
    logic [1:0]  insert_status;
    logic        last_of_run;
    logic        none_tried;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;

    metatile_board board = new();

    // Idle rates in percent for each side; changed between phases.
    int unsigned send_idle = 25;
    int unsigned take_idle = 66;
    // When set, the receiver refuses every beat so that the block backs up.
    bit          hold_off = 1'b0;
    longint      cycles = 0;

    always #4 clk = ~clk;

    tile_ancestor_dedup_hash_set dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .tile_zoom(tile_zoom), .tile_x(tile_x), .tile_y(tile_y),
        .empty(empty), .pop(pop), .meta_level(meta_level), .meta_x(meta_x),
        .meta_y(meta_y), .insert_status(insert_status), .last_of_run(last_of_run),
        .none_tried(none_tried), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // Watchdog on the cycle count.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: pop is decided afresh at every edge, and a result beat is taken
    // when pop and a non-empty queue met at that edge. The fields are sampled
    // before the nonblocking updates of this edge land.
    always @(posedge clk)
    begin
        meta_beat_t got;
        if (rst_n && pop && !empty)
        begin
            got.level = meta_level;
            got.mx = meta_x;
            got.my = meta_y;
            got.status = insert_status;
            got.last = last_of_run;
            got.none = none_tried;
            board.check_beat(got);
        end
        pop <= !hold_off && ($urandom_range(99) >= take_idle);
    end

    // Offer one tile beat and hold it until the block takes it; the predictor
    // notes it at the edge where it is accepted. Random idle cycles go first.
    // push stays high after acceptance until the caller or the next idle
    // cycle lowers it, so back-to-back tiles need no gap.
    task automatic send_tile(logic [4:0] z, logic [21:0] x, logic [21:0] y);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        tile_zoom <= z;
        tile_x <= x;
        tile_y <= y;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_tile(z, x, y);
    endtask

    // Wait for every expected beat, then for the back unit to settle, before
    // the register may be touched.
    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_min_zoom(logic [4:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.lowest_level = v;
    endtask

    // Mostly tiles that share ancestors with recent ones, so that walks end
    // early on present keys; the rest are fully random, zoom above range too.
    task automatic random_tiles(int count);
        logic [4:0]  z;
        logic [21:0] x, y;
        logic [21:0] bx = '0, by = '0;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 70)
            begin
                z = 5'($urandom_range(22, 10));
                x = 22'((bx >> (22 - z)) + $urandom_range(3));
                y = 22'((by >> (22 - z)) + $urandom_range(3));
            end
            else
            begin
                z = 5'($urandom_range(31));
                x = 22'($urandom);
                y = 22'($urandom);
                bx = x;
                by = y;
            end
            send_tile(z, x, y);
        end
        push <= 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset minimum: extremes of coordinates, zoom
        // above range, start below the minimum, repeats and shared parents.
        send_tile(5'd22, 22'h3FFFFF, 22'h3FFFFF);
        send_tile(5'd22, 22'h3FFFFF, 22'h3FFFFF);
        send_tile(5'd31, 22'h000000, 22'h000000);
        send_tile(5'd23, 22'h2AAAAA, 22'h155555);
        send_tile(5'd0, 22'h3FFFFF, 22'h000000);
        send_tile(5'd9, 22'h0001FF, 22'h0001FF);
        send_tile(5'd10, 22'h0003FF, 22'h000000);
        send_tile(5'd16, 22'h00FFFF, 22'h00FFFE);
        send_tile(5'd18, 22'h03FFFC, 22'h03FFF8);
        push <= 1'b0;
        drain();

        // Lowest minimum: full walks down to level zero.
        set_min_zoom(5'd0);
        send_tile(5'd22, 22'h155555, 22'h2AAAAA);
        send_tile(5'd0, 22'h000000, 22'h000000);
        send_tile(5'd5, 22'h00001F, 22'h000011);
        send_tile(5'd22, 22'h155554, 22'h2AAAAA);
        push <= 1'b0;
        drain();

        // Highest minimum: only the deepest level is tried, or none at all.
        set_min_zoom(5'd25);
        send_tile(5'd22, 22'h0F0F0F, 22'h30F0F0);
        send_tile(5'd22, 22'h0F0F0F, 22'h30F0F0);
        send_tile(5'd21, 22'h0F0F0F, 22'h30F0F0);
        send_tile(5'd30, 22'h000001, 22'h000002);
        push <= 1'b0;
        drain();

        // Back-pressure: the receiver holds off for a long stretch while tiles
        // keep arriving, so the queues fill and full rises.
        set_min_zoom(5'd4);
        hold_off = 1'b1;
        fork
            random_tiles(30);
            begin
                repeat (1500) @(posedge clk);
                hold_off = 1'b0;
            end
        join
        drain();

        set_min_zoom(5'd12);
        random_tiles(RANDOM_TILES / 3);
        drain();

        send_idle = 66;
        take_idle = 25;
        set_min_zoom(5'd7);
        random_tiles(RANDOM_TILES / 3);
        drain();

        send_idle = 0;
        take_idle = 0;
        set_min_zoom(5'd17);
        random_tiles(RANDOM_TILES / 3);
        drain();

        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

@@ tile_ancestor_dedup_hash_set.f @@
hdl/tad_pkg.sv
hdl/tad_ram.sv
hdl/tad_queue.sv
hdl/tad_front.sv
hdl/tad_back.sv
hdl/tile_ancestor_dedup_hash_set.sv
test/tb_tile_ancestor_dedup_hash_set.sv
